### design/macroblock_mode_and_skip_decider_top_macros.svh
// Assertion macros for the macroblock mode and skip decider.
// Included by the checker; needs no other file.
`ifndef MACROBLOCK_MODE_AND_SKIP_DECIDER_TOP_MACROS_SVH
`define MACROBLOCK_MODE_AND_SKIP_DECIDER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MBMSD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mbmsd assertion failed");

// Next-cycle implication, disabled during reset.
`define MBMSD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mbmsd assertion failed");

`endif

### design/mbmsd_pkg.sv
// Shared types and constants of the macroblock mode and skip decider.
// Used by the result queue, the top level and the checker.
package mbmsd_pkg;

  localparam int MAX_FRAME_DIM_DEF = 4096;
  localparam int CFG_W = 13;
  localparam int THR_W = 17;
  localparam int GRAD_W = 16;
  localparam int SAD_W = 17;
  localparam int RUN_W = 17;
  localparam int POS_W = 12;
  localparam int PIX_W = 8;
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = 2;
  localparam int OUT_CNT_W = 3;

  localparam logic [1:0] REG_FRAME_WIDTH = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SKIP_THRESHOLD = 2'd2;

  typedef enum logic [1:0] {
    EV_INTRA = 2'd0,
    EV_SKIP_RUN = 2'd1,
    EV_CODED = 2'd2
  } event_kind_t;

  typedef enum logic [1:0] {
    MODE_VERT = 2'd0,
    MODE_HORIZ = 2'd1,
    MODE_DC = 2'd2
  } intra_mode_t;

  typedef struct packed {
    event_kind_t kind;
    intra_mode_t mode;
    logic [RUN_W-1:0] count;
    logic item_last;
    logic frame_last;
  } result_t;

  typedef struct packed {
    logic [1:0] num;
    result_t first;
    result_t second;
  } push_t;

endpackage

### design/mbmsd_out_fifo.sv
// Result queue of the macroblock mode and skip decider.
// Takes up to two results per cycle and hands out one per cycle while out_stall is low; uses mbmsd_pkg.
module mbmsd_out_fifo (
  input  logic clk,
  input  logic rst_n,
  input  mbmsd_pkg::push_t push,
  output logic [mbmsd_pkg::OUT_CNT_W-1:0] free_slots,
  output logic out_valid,
  input  logic out_stall,
  output mbmsd_pkg::result_t out_data
);

  mbmsd_pkg::result_t mem_r [mbmsd_pkg::OUT_DEPTH];
  logic [mbmsd_pkg::OUT_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [mbmsd_pkg::OUT_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [mbmsd_pkg::OUT_CNT_W-1:0] count_r, count_nxt;
  logic pop;

  assign out_valid = (count_r != '0);
  assign out_data = mem_r[rd_ptr_r];
  assign pop = out_valid && !out_stall;
  assign free_slots = mbmsd_pkg::OUT_CNT_W'(mbmsd_pkg::OUT_DEPTH) - count_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + mbmsd_pkg::OUT_PTR_W'(push.num);
    rd_ptr_nxt = rd_ptr_r + mbmsd_pkg::OUT_PTR_W'(pop);
    count_nxt = count_r + mbmsd_pkg::OUT_CNT_W'(push.num) - mbmsd_pkg::OUT_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem_r[wr_ptr_r] <= push.first;
    end
    if (push.num == 2'd2) begin
      mem_r[wr_ptr_r + mbmsd_pkg::OUT_PTR_W'(1)] <= push.second;
    end
  end

endmodule

### design/macroblock_mode_and_skip_decider_top.sv
// Top level of the macroblock mode and skip decider.
// Holds the configuration registers, the input register and the decision logic;
// uses mbmsd_pkg and mbmsd_out_fifo.
//
// The block takes one pixel transaction per clock while in_stall is low. Each
// accepted pixel sits in an input register, where its gradient and SAD terms are
// added to saturating accumulators; on the last pixel of a macroblock the intra
// mode or skip decision is made in that same cycle and up to two results enter a
// four-entry result queue, which offers them on the output in order. A pixel
// leaves the input register only when the queue has at least two free entries,
// and the input stalls only while a pixel is held for that reason, so a full
// pixel per clock is sustained as long as results are taken.
module macroblock_mode_and_skip_decider_top #(
  parameter int MAX_FRAME_DIM = mbmsd_pkg::MAX_FRAME_DIM_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [mbmsd_pkg::THR_W-1:0] cfg_wdata,
  input  logic in_valid,
  output logic in_stall,
  input  logic [mbmsd_pkg::PIX_W-1:0] in_cur_pixel,
  input  logic [mbmsd_pkg::PIX_W-1:0] in_right_pixel,
  input  logic [mbmsd_pkg::PIX_W-1:0] in_below_pixel,
  input  logic [mbmsd_pkg::PIX_W-1:0] in_prev_pixel,
  input  logic [mbmsd_pkg::POS_W-1:0] in_pos_x,
  input  logic [mbmsd_pkg::POS_W-1:0] in_pos_y,
  input  logic in_mb_end,
  input  logic in_frame_end,
  input  logic in_intra_frame,
  input  logic in_prev_valid,
  output logic out_valid,
  input  logic out_stall,
  output logic [1:0] out_event_kind,
  output logic [1:0] out_intra_mode,
  output logic [mbmsd_pkg::RUN_W-1:0] out_skip_count,
  output logic out_item_last,
  output logic out_frame_last
);

  localparam int DIM_W = $clog2(MAX_FRAME_DIM + 1);
  localparam int CMP_W = ((DIM_W > mbmsd_pkg::CFG_W) ? DIM_W : mbmsd_pkg::CFG_W) + 1;

  logic [mbmsd_pkg::CFG_W-1:0] width_r, height_r;
  logic [mbmsd_pkg::THR_W-1:0] thr_r;

  logic s1_valid_r;
  logic [mbmsd_pkg::PIX_W-1:0] cur_r, right_r, below_r, prev_r;
  logic [mbmsd_pkg::POS_W-1:0] px_r, py_r;
  logic mb_end_r, frame_end_r, intra_r, prev_valid_r;

  logic [mbmsd_pkg::GRAD_W-1:0] vert_r, vert_nxt, horiz_r, horiz_nxt;
  logic [mbmsd_pkg::SAD_W-1:0] sad_r, sad_nxt;
  logic [mbmsd_pkg::RUN_W-1:0] run_r, run_nxt;

  logic [CMP_W-1:0] w_clamp, h_clamp, px_ext, py_ext;
  logic grad_en, sad_en, go, in_accept;
  logic [mbmsd_pkg::PIX_W-1:0] v_abs, h_abs, s_abs;
  logic [mbmsd_pkg::GRAD_W:0] v_wide, h_wide;
  logic [mbmsd_pkg::SAD_W:0] s_wide;
  logic [mbmsd_pkg::RUN_W:0] run_wide;
  logic [mbmsd_pkg::GRAD_W-1:0] v_sum, h_sum;
  logic [mbmsd_pkg::SAD_W-1:0] s_sum;
  logic [mbmsd_pkg::RUN_W-1:0] run_inc;
  logic [mbmsd_pkg::GRAD_W+1:0] v3, h3, v2, h2;
  mbmsd_pkg::intra_mode_t mode;
  mbmsd_pkg::push_t push;
  mbmsd_pkg::result_t head;
  logic [mbmsd_pkg::OUT_CNT_W-1:0] free_slots;

  function automatic logic [mbmsd_pkg::PIX_W-1:0] abs_diff(
    input logic [mbmsd_pkg::PIX_W-1:0] a,
    input logic [mbmsd_pkg::PIX_W-1:0] b
  );
    return (a > b) ? (a - b) : (b - a);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= mbmsd_pkg::CFG_W'(1920);
      height_r <= mbmsd_pkg::CFG_W'(1080);
      thr_r <= mbmsd_pkg::THR_W'(512);
    end else if (cfg_we) begin
      case (cfg_index)
        mbmsd_pkg::REG_FRAME_WIDTH: width_r <= cfg_wdata[mbmsd_pkg::CFG_W-1:0];
        mbmsd_pkg::REG_FRAME_HEIGHT: height_r <= cfg_wdata[mbmsd_pkg::CFG_W-1:0];
        mbmsd_pkg::REG_SKIP_THRESHOLD: thr_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign go = s1_valid_r && (free_slots >= mbmsd_pkg::OUT_CNT_W'(2));
  assign in_stall = s1_valid_r && !go;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cur_r <= in_cur_pixel;
      right_r <= in_right_pixel;
      below_r <= in_below_pixel;
      prev_r <= in_prev_pixel;
      px_r <= in_pos_x;
      py_r <= in_pos_y;
      mb_end_r <= in_mb_end;
      frame_end_r <= in_frame_end;
      intra_r <= in_intra_frame;
      prev_valid_r <= in_prev_valid;
    end
  end

  always_comb begin
    w_clamp = (CMP_W'(width_r) > CMP_W'(MAX_FRAME_DIM)) ? CMP_W'(MAX_FRAME_DIM)
                                                        : CMP_W'(width_r);
    h_clamp = (CMP_W'(height_r) > CMP_W'(MAX_FRAME_DIM)) ? CMP_W'(MAX_FRAME_DIM)
                                                         : CMP_W'(height_r);
    px_ext = CMP_W'(px_r);
    py_ext = CMP_W'(py_r);
    grad_en = (px_r[3:0] != 4'hF) && (py_r[3:0] != 4'hF) &&
              (px_ext + CMP_W'(1) < w_clamp) && (py_ext + CMP_W'(1) < h_clamp);
    sad_en = prev_valid_r && (px_ext < w_clamp) && (py_ext < h_clamp);

    v_abs = grad_en ? abs_diff(cur_r, below_r) : '0;
    h_abs = grad_en ? abs_diff(cur_r, right_r) : '0;
    s_abs = sad_en ? abs_diff(cur_r, prev_r) : '0;
    v_wide = {1'b0, vert_r} + (mbmsd_pkg::GRAD_W + 1)'(v_abs);
    h_wide = {1'b0, horiz_r} + (mbmsd_pkg::GRAD_W + 1)'(h_abs);
    s_wide = {1'b0, sad_r} + (mbmsd_pkg::SAD_W + 1)'(s_abs);
    v_sum = v_wide[mbmsd_pkg::GRAD_W] ? '1 : v_wide[mbmsd_pkg::GRAD_W-1:0];
    h_sum = h_wide[mbmsd_pkg::GRAD_W] ? '1 : h_wide[mbmsd_pkg::GRAD_W-1:0];
    s_sum = s_wide[mbmsd_pkg::SAD_W] ? '1 : s_wide[mbmsd_pkg::SAD_W-1:0];
    run_wide = {1'b0, run_r} + (mbmsd_pkg::RUN_W + 1)'(1);
    run_inc = run_wide[mbmsd_pkg::RUN_W] ? '1 : run_wide[mbmsd_pkg::RUN_W-1:0];

    v2 = {1'b0, v_sum, 1'b0};
    h2 = {1'b0, h_sum, 1'b0};
    v3 = v2 + (mbmsd_pkg::GRAD_W + 2)'(v_sum);
    h3 = h2 + (mbmsd_pkg::GRAD_W + 2)'(h_sum);
    if (v3 < h2) begin
      mode = mbmsd_pkg::MODE_VERT;
    end else if (h3 < v2) begin
      mode = mbmsd_pkg::MODE_HORIZ;
    end else begin
      mode = mbmsd_pkg::MODE_DC;
    end

    push = '0;
    push.first.kind = mbmsd_pkg::EV_INTRA;
    push.first.mode = mbmsd_pkg::MODE_VERT;
    push.second.kind = mbmsd_pkg::EV_CODED;
    push.second.mode = mbmsd_pkg::MODE_VERT;
    push.second.item_last = 1'b1;
    push.second.frame_last = frame_end_r;
    vert_nxt = vert_r;
    horiz_nxt = horiz_r;
    sad_nxt = sad_r;
    run_nxt = run_r;

    if (go) begin
      vert_nxt = v_sum;
      horiz_nxt = h_sum;
      sad_nxt = s_sum;
      if (mb_end_r) begin
        vert_nxt = '0;
        horiz_nxt = '0;
        sad_nxt = '0;
        if (intra_r) begin
          push.num = 2'd1;
          push.first.kind = mbmsd_pkg::EV_INTRA;
          push.first.mode = mode;
          push.first.item_last = 1'b1;
          push.first.frame_last = frame_end_r;
          run_nxt = '0;
        end else if (s_sum < thr_r) begin
          run_nxt = run_inc;
          if (frame_end_r) begin
            push.num = 2'd1;
            push.first.kind = mbmsd_pkg::EV_SKIP_RUN;
            push.first.count = run_inc;
            push.first.item_last = 1'b1;
            push.first.frame_last = 1'b1;
            run_nxt = '0;
          end
        end else begin
          run_nxt = '0;
          if (run_r != '0) begin
            push.num = 2'd2;
            push.first.kind = mbmsd_pkg::EV_SKIP_RUN;
            push.first.count = run_r;
          end else begin
            push.num = 2'd1;
            push.first.kind = mbmsd_pkg::EV_CODED;
            push.first.item_last = 1'b1;
            push.first.frame_last = frame_end_r;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vert_r <= '0;
      horiz_r <= '0;
      sad_r <= '0;
      run_r <= '0;
    end else begin
      vert_r <= vert_nxt;
      horiz_r <= horiz_nxt;
      sad_r <= sad_nxt;
      run_r <= run_nxt;
    end
  end

  mbmsd_out_fifo u_out_fifo (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .free_slots(free_slots),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(head)
  );

  assign out_event_kind = head.kind;
  assign out_intra_mode = head.mode;
  assign out_skip_count = head.count;
  assign out_item_last = head.item_last;
  assign out_frame_last = head.frame_last;

endmodule

### design/mbmsd_checker.sv
// Port-level checker for the macroblock mode and skip decider, bound to the top.
// Uses mbmsd_pkg and the macros header.
`include "macroblock_mode_and_skip_decider_top_macros.svh"

module mbmsd_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_stall,
  input logic [1:0] out_event_kind,
  input logic [1:0] out_intra_mode,
  input logic [mbmsd_pkg::RUN_W-1:0] out_skip_count,
  input logic out_item_last,
  input logic out_frame_last
);

  // A result that is held back stays offered.
  `MBMSD_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

  // A skip run transaction never reports an empty run.
  `MBMSD_ASSERT_IMP(a_run_nonzero, clk, rst_n, out_valid && (out_event_kind == mbmsd_pkg::EV_SKIP_RUN), out_skip_count != '0)

  // Only a run that precedes a coded block can leave the item open.
  `MBMSD_ASSERT_IMP(a_open_is_run, clk, rst_n, out_valid && !out_item_last, (out_event_kind == mbmsd_pkg::EV_SKIP_RUN) && !out_frame_last)

  // Intra results carry no run length and close their item.
  `MBMSD_ASSERT_IMP(a_intra_clean, clk, rst_n, out_valid && (out_event_kind == mbmsd_pkg::EV_INTRA), out_item_last && (out_skip_count == '0))

  // Results other than intra carry a zero mode.
  `MBMSD_ASSERT_IMP(a_mode_clean, clk, rst_n, out_valid && (out_event_kind != mbmsd_pkg::EV_INTRA), out_intra_mode == mbmsd_pkg::MODE_VERT)

endmodule

bind macroblock_mode_and_skip_decider_top mbmsd_checker u_mbmsd_checker (
  .clk(clk),
  .rst_n(rst_n),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_event_kind(out_event_kind),
  .out_intra_mode(out_intra_mode),
  .out_skip_count(out_skip_count),
  .out_item_last(out_item_last),
  .out_frame_last(out_frame_last)
);

### tb/tb_macroblock_mode_and_skip_decider_top.sv
// Self-checking testbench for the macroblock mode and skip decider top level.
// Drives pixel transactions, predicts intra-mode and skip-run results, and checks them in order.
// Depends only on mbmsd_pkg and macroblock_mode_and_skip_decider_top.
module tb_macroblock_mode_and_skip_decider_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mbmsd_pkg::*;

  localparam int DRAIN_CYCLES = 8;
  localparam int PRINT_LIMIT = 20;
  localparam int LONG_RUN_ITEMS = 40;

  typedef struct {
    logic [PIX_W-1:0] cur;
    logic [PIX_W-1:0] right;
    logic [PIX_W-1:0] below;
    logic [PIX_W-1:0] prev;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic mb_end;
    logic frame_end;
    logic intra;
    logic prev_valid;
  } pixel_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [THR_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_stall;
  logic [PIX_W-1:0] in_cur_pixel;
  logic [PIX_W-1:0] in_right_pixel;
  logic [PIX_W-1:0] in_below_pixel;
  logic [PIX_W-1:0] in_prev_pixel;
  logic [POS_W-1:0] in_pos_x;
  logic [POS_W-1:0] in_pos_y;
  logic in_mb_end;
  logic in_frame_end;
  logic in_intra_frame;
  logic in_prev_valid;
  logic out_valid;
  logic out_stall;
  logic [1:0] out_event_kind;
  logic [1:0] out_intra_mode;
  logic [RUN_W-1:0] out_skip_count;
  logic out_item_last;
  logic out_frame_last;

  logic [CFG_W-1:0] cfg_width;
  logic [CFG_W-1:0] cfg_height;
  logic [THR_W-1:0] cfg_threshold;
  logic [GRAD_W-1:0] grad_v_acc;
  logic [GRAD_W-1:0] grad_h_acc;
  logic [SAD_W-1:0] sad_acc;
  logic [RUN_W-1:0] run_len;

  result_t expected_events[$];
  int errors;
  int pixels_sent;
  int results_checked;
  int settings_written;
  int idle_pct;
  int stall_pct;

  macroblock_mode_and_skip_decider_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_cur_pixel(in_cur_pixel),
    .in_right_pixel(in_right_pixel),
    .in_below_pixel(in_below_pixel),
    .in_prev_pixel(in_prev_pixel),
    .in_pos_x(in_pos_x),
    .in_pos_y(in_pos_y),
    .in_mb_end(in_mb_end),
    .in_frame_end(in_frame_end),
    .in_intra_frame(in_intra_frame),
    .in_prev_valid(in_prev_valid),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_event_kind(out_event_kind),
    .out_intra_mode(out_intra_mode),
    .out_skip_count(out_skip_count),
    .out_item_last(out_item_last),
    .out_frame_last(out_frame_last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("tb_macroblock_mode_and_skip_decider_top: FAIL");
    $finish;
  end

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  function automatic int unsigned absdiff(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
    return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
  endfunction

  function automatic int unsigned sat_sum(int unsigned acc, int unsigned v, int unsigned lim);
    int unsigned s;
    s = acc + v;
    return (s > lim) ? lim : s;
  endfunction

  function automatic int clamp_dim(logic [CFG_W-1:0] d);
    return (int'(d) > MAX_FRAME_DIM_DEF) ? MAX_FRAME_DIM_DEF : int'(d);
  endfunction

  function automatic logic [PIX_W-1:0] near_value(logic [PIX_W-1:0] v, int spread);
    int r;
    r = $urandom_range(0, 2 * spread);
    r = int'(v) + r - spread;
    if (r < 0) r = 0;
    if (r > 255) r = 255;
    return PIX_W'(r);
  endfunction

  function automatic pixel_t mk_pixel(int cur, int right, int below, int prev, int x, int y,
                                      bit mb, bit fe, bit intra, bit pv);
    pixel_t p;
    p.cur = PIX_W'(cur);
    p.right = PIX_W'(right);
    p.below = PIX_W'(below);
    p.prev = PIX_W'(prev);
    p.x = POS_W'(x);
    p.y = POS_W'(y);
    p.mb_end = mb;
    p.frame_end = fe;
    p.intra = intra;
    p.prev_valid = pv;
    return p;
  endfunction

  function automatic void push_event(event_kind_t kind, intra_mode_t mode, int unsigned cnt,
                                     bit il, bit fl);
    result_t r;
    r.kind = kind;
    r.mode = mode;
    r.count = RUN_W'(cnt);
    r.item_last = il;
    r.frame_last = fl;
    expected_events.push_back(r);
  endfunction

  function automatic void predict_decision(pixel_t p);
    int w;
    int h;
    intra_mode_t mode;
    w = clamp_dim(cfg_width);
    h = clamp_dim(cfg_height);
    if (p.x[3:0] != 4'd15 && p.y[3:0] != 4'd15 && int'(p.x) + 1 < w && int'(p.y) + 1 < h) begin
      grad_v_acc = GRAD_W'(sat_sum(grad_v_acc, absdiff(p.cur, p.below), 16'hFFFF));
      grad_h_acc = GRAD_W'(sat_sum(grad_h_acc, absdiff(p.cur, p.right), 16'hFFFF));
    end
    if (p.prev_valid && int'(p.x) < w && int'(p.y) < h)
      sad_acc = SAD_W'(sat_sum(sad_acc, absdiff(p.cur, p.prev), 17'h1FFFF));
    if (!p.mb_end) return;
    if (p.intra) begin
      mode = MODE_DC;
      if (3 * int'(grad_v_acc) < 2 * int'(grad_h_acc)) mode = MODE_VERT;
      else if (3 * int'(grad_h_acc) < 2 * int'(grad_v_acc)) mode = MODE_HORIZ;
      push_event(EV_INTRA, mode, 0, 1'b1, p.frame_end);
      run_len = '0;
    end else if (sad_acc < cfg_threshold) begin
      run_len = RUN_W'(sat_sum(run_len, 1, 17'h1FFFF));
      if (p.frame_end) begin
        push_event(EV_SKIP_RUN, MODE_VERT, run_len, 1'b1, 1'b1);
        run_len = '0;
      end
    end else begin
      if (run_len != 0) begin
        push_event(EV_SKIP_RUN, MODE_VERT, run_len, 1'b0, 1'b0);
        run_len = '0;
      end
      push_event(EV_CODED, MODE_VERT, 0, 1'b1, p.frame_end);
    end
    grad_v_acc = '0;
    grad_h_acc = '0;
    sad_acc = '0;
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  always @(negedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      if (expected_events.size() == 0) begin
        report_mismatch($sformatf("result transaction kind %0d with none expected",
                                  out_event_kind));
      end else begin
        want = expected_events.pop_front();
        if (out_event_kind !== want.kind)
          report_mismatch($sformatf("event_kind %0d, expected %0d", out_event_kind, want.kind));
        if (out_intra_mode !== want.mode)
          report_mismatch($sformatf("intra_mode %0d, expected %0d", out_intra_mode, want.mode));
        if (out_skip_count !== want.count)
          report_mismatch($sformatf("skip_count %0d, expected %0d", out_skip_count, want.count));
        if (out_item_last !== want.item_last)
          report_mismatch($sformatf("item_last %0b, expected %0b", out_item_last,
                                    want.item_last));
        if (out_frame_last !== want.frame_last)
          report_mismatch($sformatf("frame_last %0b, expected %0b", out_frame_last,
                                    want.frame_last));
      end
    end
  end

  task automatic send_pixel(pixel_t p);
    bit accepted;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cur_pixel <= p.cur;
    in_right_pixel <= p.right;
    in_below_pixel <= p.below;
    in_prev_pixel <= p.prev;
    in_pos_x <= p.x;
    in_pos_y <= p.y;
    in_mb_end <= p.mb_end;
    in_frame_end <= p.frame_end;
    in_intra_frame <= p.intra;
    in_prev_valid <= p.prev_valid;
    predict_decision(p);
    pixels_sent++;
    accepted = 1'b0;
    while (!accepted) begin
      @(negedge clk);
      accepted = !in_stall;
      @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(int w, int h, int thr);
    cfg_we <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_wdata <= THR_W'(CFG_W'(w));
    @(posedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_wdata <= THR_W'(CFG_W'(h));
    @(posedge clk);
    cfg_index <= REG_SKIP_THRESHOLD;
    cfg_wdata <= THR_W'(thr);
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_width = CFG_W'(w);
    cfg_height = CFG_W'(h);
    cfg_threshold = THR_W'(thr);
    settings_written++;
  endtask

  task automatic send_mb(int npix, bit intra, bit pv, bit fend);
    int style;
    int delta;
    int nx;
    int ny;
    int bx;
    int by;
    pixel_t p;
    style = $urandom_range(0, 2);
    delta = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : $urandom_range(0, 80);
    nx = (clamp_dim(cfg_width) > 0) ? (clamp_dim(cfg_width) - 1) / 16 : 0;
    ny = (clamp_dim(cfg_height) > 0) ? (clamp_dim(cfg_height) - 1) / 16 : 0;
    if ($urandom_range(0, 3) != 0) begin
      bx = 16 * $urandom_range(0, nx);
      by = 16 * $urandom_range(0, ny);
    end else begin
      bx = 16 * $urandom_range(0, 255);
      by = 16 * $urandom_range(0, 255);
    end
    for (int i = 0; i < npix; i++) begin
      p.cur = PIX_W'($urandom);
      p.right = (style == 1) ? near_value(p.cur, 4) : PIX_W'($urandom);
      p.below = (style == 0) ? near_value(p.cur, 4) : PIX_W'($urandom);
      p.prev = near_value(p.cur, delta);
      if (npix == 256) begin
        p.x = POS_W'(bx + i % 16);
        p.y = POS_W'(by + i / 16);
      end else begin
        p.x = POS_W'(bx + $urandom_range(0, 15));
        p.y = POS_W'(by + $urandom_range(0, 15));
      end
      p.mb_end = (i == npix - 1);
      p.frame_end = fend && (i == npix - 1);
      p.intra = intra;
      p.prev_valid = pv;
      send_pixel(p);
    end
  endtask

  task automatic test_intra_modes();
    wait_idle();
    write_config(1920, 1080, 512);
    send_pixel(mk_pixel(0, 255, 0, 0, 0, 0, 1, 0, 1, 1));
    send_pixel(mk_pixel(255, 255, 0, 0, 1, 1, 1, 0, 1, 1));
    send_pixel(mk_pixel(0, 0, 0, 0, 2, 2, 1, 0, 1, 1));
    send_pixel(mk_pixel(128, 128, 128, 255, 4095, 4095, 1, 1, 1, 1));
  endtask

  task automatic test_window_edges();
    wait_idle();
    write_config(1920, 1080, 512);
    send_pixel(mk_pixel(255, 255, 0, 0, 15, 0, 0, 0, 1, 1));
    send_pixel(mk_pixel(255, 255, 0, 0, 0, 15, 0, 0, 1, 1));
    send_pixel(mk_pixel(255, 255, 0, 0, 1919, 5, 0, 0, 1, 1));
    send_pixel(mk_pixel(255, 255, 0, 0, 5, 1079, 0, 0, 1, 1));
    send_pixel(mk_pixel(0, 255, 0, 0, 1918, 1078, 0, 1, 1, 1));
    send_pixel(mk_pixel(0, 0, 0, 0, 1918, 1078, 1, 0, 1, 1));
  endtask

  task automatic test_skip_runs();
    wait_idle();
    write_config(1920, 1080, 512);
    send_pixel(mk_pixel(200, 0, 0, 0, 0, 0, 1, 0, 0, 0));
    send_pixel(mk_pixel(200, 0, 0, 0, 0, 0, 1, 0, 0, 0));
    send_pixel(mk_pixel(255, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    send_pixel(mk_pixel(0, 0, 0, 255, 1, 0, 0, 0, 0, 1));
    send_pixel(mk_pixel(255, 0, 0, 0, 2, 0, 1, 0, 0, 1));
    send_pixel(mk_pixel(255, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    send_pixel(mk_pixel(255, 0, 0, 0, 0, 1, 0, 0, 0, 1));
    send_pixel(mk_pixel(255, 0, 0, 0, 0, 2, 1, 0, 0, 1));
    send_pixel(mk_pixel(9, 0, 0, 0, 0, 0, 1, 0, 0, 0));
    send_pixel(mk_pixel(0, 255, 0, 0, 0, 0, 1, 0, 1, 1));
    send_pixel(mk_pixel(9, 0, 0, 0, 0, 0, 1, 0, 0, 0));
    send_pixel(mk_pixel(9, 0, 0, 0, 0, 0, 1, 1, 0, 0));
    send_pixel(mk_pixel(255, 0, 0, 0, 1920, 0, 0, 0, 0, 1));
    send_pixel(mk_pixel(255, 0, 0, 0, 0, 1080, 0, 0, 0, 1));
    send_pixel(mk_pixel(255, 0, 0, 0, 4095, 4095, 1, 0, 0, 1));
    send_pixel(mk_pixel(255, 0, 0, 0, 16, 16, 0, 0, 0, 1));
    send_pixel(mk_pixel(255, 0, 0, 0, 17, 16, 0, 0, 0, 1));
    send_pixel(mk_pixel(255, 0, 0, 0, 18, 16, 1, 1, 0, 1));
  endtask

  task automatic test_dimension_extremes();
    wait_idle();
    write_config(0, 0, 0);
    send_pixel(mk_pixel(0, 255, 0, 255, 0, 0, 1, 0, 1, 1));
    send_pixel(mk_pixel(0, 255, 0, 255, 0, 0, 1, 1, 0, 1));
    wait_idle();
    write_config(8191, 8191, 131071);
    send_pixel(mk_pixel(0, 255, 0, 0, 4095, 4094, 1, 0, 1, 1));
    send_pixel(mk_pixel(255, 0, 0, 0, 4095, 4095, 1, 0, 0, 1));
    send_pixel(mk_pixel(255, 0, 0, 0, 4095, 4095, 1, 1, 0, 1));
    wait_idle();
    write_config(1, 1, 1);
    send_pixel(mk_pixel(0, 255, 255, 0, 0, 0, 1, 0, 0, 1));
    send_pixel(mk_pixel(1, 0, 0, 0, 0, 0, 1, 1, 0, 1));
  endtask

  task automatic test_random_frames(int w, int h, int thr, int n_pixels);
    int start;
    int n_mb;
    bit intra;
    bit pv;
    pixel_t p;
    wait_idle();
    write_config(w, h, thr);
    start = pixels_sent;
    while (pixels_sent - start < n_pixels) begin
      n_mb = $urandom_range(1, 6);
      intra = ($urandom_range(0, 9) < 3);
      pv = ($urandom_range(0, 7) != 0);
      for (int m = 0; m < n_mb; m++) begin
        if ($urandom_range(0, 9) == 0) begin
          p.cur = PIX_W'($urandom);
          p.right = PIX_W'($urandom);
          p.below = PIX_W'($urandom);
          p.prev = PIX_W'($urandom);
          p.x = POS_W'($urandom);
          p.y = POS_W'($urandom);
          p.mb_end = 1'($urandom);
          p.frame_end = 1'($urandom);
          p.intra = 1'($urandom);
          p.prev_valid = 1'($urandom);
          send_pixel(p);
        end
        send_mb(($urandom_range(0, 24) == 0) ? 256 : $urandom_range(1, 16), intra, pv,
                m == n_mb - 1);
      end
    end
  endtask

  task automatic test_saturation();
    wait_idle();
    write_config(1920, 1080, 131071);
    repeat (300) send_pixel(mk_pixel(255, 255, 0, 0, 0, 0, 0, 0, 1, 1));
    repeat (172) send_pixel(mk_pixel(255, 0, 255, 0, 0, 0, 0, 0, 1, 1));
    send_pixel(mk_pixel(255, 0, 255, 0, 0, 0, 1, 0, 1, 1));
    repeat (520) send_pixel(mk_pixel(255, 0, 0, 0, 3, 3, 0, 0, 0, 1));
    send_pixel(mk_pixel(255, 0, 0, 0, 3, 3, 1, 0, 0, 1));
    repeat (LONG_RUN_ITEMS) send_pixel(mk_pixel(0, 0, 0, 0, 0, 0, 1, 0, 0, 0));
    send_pixel(mk_pixel(0, 0, 0, 0, 0, 0, 1, 1, 0, 0));
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_cur_pixel <= '0;
    in_right_pixel <= '0;
    in_below_pixel <= '0;
    in_prev_pixel <= '0;
    in_pos_x <= '0;
    in_pos_y <= '0;
    in_mb_end <= 1'b0;
    in_frame_end <= 1'b0;
    in_intra_frame <= 1'b0;
    in_prev_valid <= 1'b0;
    cfg_width = 13'd1920;
    cfg_height = 13'd1080;
    cfg_threshold = 17'd512;
    grad_v_acc = '0;
    grad_h_acc = '0;
    sad_acc = '0;
    run_len = '0;
    errors = 0;
    pixels_sent = 0;
    results_checked = 0;
    settings_written = 0;
    idle_pct = 28;
    stall_pct = 80;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_intra_modes();
    test_window_edges();
    test_skip_runs();
    test_dimension_extremes();
    test_random_frames(1920, 1080, $urandom_range(100, 2000), 320);

    idle_pct = 80;
    stall_pct = 28;
    test_random_frames(4096, 8191, $urandom_range(0, 4000), 320);

    idle_pct = 0;
    stall_pct = 0;
    test_saturation();
    test_random_frames($urandom_range(1, 200), $urandom_range(1, 200),
                       $urandom_range(0, 3000), 320);

    wait_idle();
    if (expected_events.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", expected_events.size()));
    $display("Sent %0d pixel transactions under %0d register settings and checked %0d results.",
             pixels_sent, settings_written, results_checked);
    $display("Mismatches found: %0d.", errors);
    if (errors == 0) begin
      $display("tb_macroblock_mode_and_skip_decider_top: PASS");
    end else begin
      $display("tb_macroblock_mode_and_skip_decider_top: FAIL");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/mbmsd_pkg.sv
design/mbmsd_out_fifo.sv
design/macroblock_mode_and_skip_decider_top.sv
design/mbmsd_checker.sv
tb/tb_macroblock_mode_and_skip_decider_top.sv
